// ===== rtl/core/plgq_pkg.sv =====
package plgq_pkg;

  localparam int MaxPoints = 64;
  localparam int MaxLinks = 64;
  localparam int PIdxW = $clog2(MaxPoints);
  localparam int LIdxW = $clog2(MaxLinks);
  localparam int PCntW = $clog2(MaxPoints + 1);
  localparam int LCntW = $clog2(MaxLinks + 1);
  localparam int CoordW = 16;
  localparam int RadiusW = 10;
  localparam int TolW = 16;
  localparam int CfgW = 16;
  localparam int CfgIdxW = 1;
  localparam int DistW = 35;
  localparam int CrossW = 35;

  localparam logic [RadiusW-1:0] HitRadiusRst = RadiusW'(40);
  localparam logic [TolW-1:0] LineTolRst = TolW'(1000);

  localparam logic [CfgIdxW-1:0] CfgHitRadius = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgLineTol = 1'b1;

  typedef enum logic [2:0] {
    OP_ADD_POINT = 3'd0,
    OP_ADD_LINK = 3'd1,
    OP_HIT_POINT = 3'd2,
    OP_NEAR_POINT = 3'd3,
    OP_NEAR_LINK = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_NO_END = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    Q_HIT,
    Q_NEAR_P,
    Q_NEAR_L,
    Q_UNDER
  } qkind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LREAD,
    S_PREAD_A,
    S_PREAD_B,
    S_EVAL,
    S_CROSS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic hit;
    logic better;
  } eval_t;

endpackage

// ===== rtl/core/plgq_eval.sv =====
module plgq_eval (
  input  logic                          clk,
  input  plgq_pkg::qkind_t              kind,
  input  logic signed [plgq_pkg::CoordW-1:0] qx,
  input  logic signed [plgq_pkg::CoordW-1:0] qy,
  input  logic signed [plgq_pkg::CoordW-1:0] ax,
  input  logic signed [plgq_pkg::CoordW-1:0] ay,
  input  logic signed [plgq_pkg::CoordW-1:0] bx,
  input  logic signed [plgq_pkg::CoordW-1:0] by,
  input  logic [plgq_pkg::RadiusW-1:0]  radius,
  input  logic [plgq_pkg::TolW-1:0]     tol,
  input  logic                          have_best,
  input  logic [plgq_pkg::DistW-1:0]    best,
  input  logic                          cross_phase,
  output plgq_pkg::eval_t               res,
  output logic [plgq_pkg::DistW-1:0]    dist_sq
);
  import plgq_pkg::*;

  logic signed [CoordW:0] px, py, dx, dy, ex, ey, qbx, qby;
  logic signed [CoordW+1:0] sx, sy, tx, ty;
  logic [CoordW+1:0] adx, ady;
  logic [2*CoordW-1:0] sqx, sqy;
  logic signed [CrossW-1:0] p1_r, p2_r, cr;
  logic inbox, box_r;
  logic [CrossW-1:0] acr;

  always_comb begin
    sx = {{2{ax[CoordW-1]}}, ax} + {{2{bx[CoordW-1]}}, bx};
    sy = {{2{ay[CoordW-1]}}, ay} + {{2{by[CoordW-1]}}, by};
    tx = sx + ((sx < 0) ? (CoordW+2)'(1) : (CoordW+2)'(0));
    ty = sy + ((sy < 0) ? (CoordW+2)'(1) : (CoordW+2)'(0));
    if (kind == Q_NEAR_L) begin
      px = tx[CoordW+1:1];
      py = ty[CoordW+1:1];
    end else begin
      px = {ax[CoordW-1], ax};
      py = {ay[CoordW-1], ay};
    end
    dx = px - {qx[CoordW-1], qx};
    dy = py - {qy[CoordW-1], qy};
    adx = (CoordW+2)'(dx < 0 ? -dx : dx);
    ady = (CoordW+2)'(dy < 0 ? -dy : dy);
    sqx = (2*CoordW)'(adx) * (2*CoordW)'(adx);
    sqy = (2*CoordW)'(ady) * (2*CoordW)'(ady);
    dist_sq = DistW'(sqx) + DistW'(sqy);
    ex = {ax[CoordW-1], ax} - {bx[CoordW-1], bx};
    ey = {ay[CoordW-1], ay} - {by[CoordW-1], by};
    qbx = {qx[CoordW-1], qx} - {bx[CoordW-1], bx};
    qby = {qy[CoordW-1], qy} - {by[CoordW-1], by};
    inbox = !(qx < ((ax < bx) ? ax : bx) || qx > ((ax < bx) ? bx : ax) ||
              qy < ((ay < by) ? ay : by) || qy > ((ay < by) ? by : ay));
    cr = p1_r - p2_r;
    acr = CrossW'(cr < 0 ? -cr : cr);
    res = '0;
    case (kind)
      Q_HIT: res.hit = adx <= (CoordW+2)'(radius) && ady <= (CoordW+2)'(radius);
      Q_NEAR_P, Q_NEAR_L: res.better = !have_best || dist_sq < best;
      Q_UNDER: res.hit = cross_phase && box_r && acr < CrossW'(tol);
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    p1_r <= CrossW'(ex) * CrossW'(qby);
    p2_r <= CrossW'(ey) * CrossW'(qbx);
    box_r <= inbox;
  end

endmodule

// ===== rtl/core/point_link_geometry_query_table_core.sv =====
// Point/link geometry query table.
// Requests enter on start with op, op_under_link, coordinates and indices
// when busy is low. Exactly one result per request appears on out_status,
// out_found and out_found_index for one cycle with out_valid high.
// Adds, unused ops and queries on an empty table go from S_LREAD straight to S_DONE.
// Hit and nearest-point scan the stored points in turn, a memory read (S_LREAD)
// then an evaluate (S_EVAL) for each; a hit query stops at its first hit.
// Nearest-link reads the link, then both endpoints from the single-port point
// memory, then evaluates. Link-under adds a cross-product step (S_CROSS) after
// each evaluate and stops at the first link that passes.
// busy drops together with out_valid rising, so the next request can be
// accepted at the edge that ends the result cycle; one request at a time.
// Configuration: cfg_we, cfg_index (0 hit_radius, 1 line_tolerance),
// cfg_wdata, written at once; the user must write only while idle; the block itself does not enforce this.
// Reset empties both tables and restores hit_radius 40, line_tolerance 1000.
// The receiver cannot stall; results are never held.
module point_link_geometry_query_table_core (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  logic [2:0] in_op,
  input  logic in_op_under_link,
  input  logic signed [15:0] in_coord_x,
  input  logic signed [15:0] in_coord_y,
  input  logic [5:0] in_end_a_index,
  input  logic [5:0] in_end_b_index,
  input  logic [5:0] in_exclude_index,
  input  logic cfg_we,
  input  logic [plgq_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [plgq_pkg::CfgW-1:0] cfg_wdata,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic out_found,
  output logic [5:0] out_found_index
);
  import plgq_pkg::*;

  logic signed [CoordW-1:0] px_mem [MaxPoints];
  logic signed [CoordW-1:0] py_mem [MaxPoints];
  logic [PIdxW-1:0] la_mem [MaxLinks];
  logic [PIdxW-1:0] lb_mem [MaxLinks];

  state_t state_r, state_nxt;
  qkind_t kind_r;
  logic [2:0] op_r;
  logic under_r;
  logic signed [CoordW-1:0] qx_r, qy_r;
  logic [PIdxW-1:0] ea_r, eb_r;
  logic [5:0] ex_r;
  logic [PCntW-1:0] pcnt_r;
  logic [LCntW-1:0] lcnt_r;
  logic [RadiusW-1:0] radius_r;
  logic [TolW-1:0] tol_r;
  logic [LCntW-1:0] i_r;
  logic [PIdxW-1:0] prd_addr;
  logic signed [CoordW-1:0] prx_r, pry_r, ax_r, ay_r;
  logic [PIdxW-1:0] lra_r, lrb_r;
  logic found_r;
  logic [5:0] idx_r;
  logic [1:0] status_r;
  logic [DistW-1:0] best_r, dist_sq;
  eval_t ev;
  logic is_link, cnt, last, skip, is_query;
  logic [LCntW-1:0] lim;

  assign is_link = kind_r == Q_NEAR_L || kind_r == Q_UNDER;
  assign lim = is_link ? lcnt_r : LCntW'(pcnt_r);
  assign cnt = i_r < lim;
  assign last = i_r + LCntW'(1) >= lim;
  assign skip = (kind_r == Q_NEAR_P || kind_r == Q_NEAR_L) && i_r == LCntW'(ex_r);
  assign is_query = under_r || op_r inside {OP_HIT_POINT, OP_NEAR_POINT, OP_NEAR_LINK};

  plgq_eval u_eval (
    .clk(clk), .kind(kind_r), .qx(qx_r), .qy(qy_r),
    .ax(is_link ? ax_r : prx_r), .ay(is_link ? ay_r : pry_r),
    .bx(prx_r), .by(pry_r), .radius(radius_r), .tol(tol_r),
    .have_best(found_r), .best(best_r), .cross_phase(state_r == S_CROSS),
    .res(ev), .dist_sq(dist_sq)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_LREAD;
      S_LREAD: begin
        if (!is_query || !cnt) state_nxt = S_DONE;
        else if (is_link) state_nxt = S_PREAD_A;
        else state_nxt = S_EVAL;
      end
      S_PREAD_A: state_nxt = S_PREAD_B;
      S_PREAD_B: state_nxt = S_EVAL;
      S_EVAL: begin
        if (kind_r == Q_UNDER) state_nxt = S_CROSS;
        else if ((kind_r == Q_HIT && ev.hit) || last) state_nxt = S_DONE;
        else state_nxt = S_LREAD;
      end
      S_CROSS: state_nxt = (ev.hit || last) ? S_DONE : S_LREAD;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    prd_addr = i_r[PIdxW-1:0];
    if (state_r == S_PREAD_A) prd_addr = lra_r;
    else if (state_r == S_PREAD_B) prd_addr = lrb_r;
  end

  always_comb begin
    busy = state_r != S_IDLE;
  end

  always_ff @(posedge clk) begin
    prx_r <= px_mem[prd_addr];
    pry_r <= py_mem[prd_addr];
    lra_r <= la_mem[i_r[LIdxW-1:0]];
    lrb_r <= lb_mem[i_r[LIdxW-1:0]];
    if (state_r == S_PREAD_B) begin
      ax_r <= prx_r;
      ay_r <= pry_r;
    end
    if (state_r == S_IDLE && start) begin
      op_r <= in_op;
      under_r <= in_op_under_link;
      qx_r <= in_coord_x;
      qy_r <= in_coord_y;
      ea_r <= in_end_a_index;
      eb_r <= in_end_b_index;
      ex_r <= in_exclude_index;
      if (in_op_under_link) kind_r <= Q_UNDER;
      else if (in_op == OP_HIT_POINT) kind_r <= Q_HIT;
      else if (in_op == OP_NEAR_POINT) kind_r <= Q_NEAR_P;
      else kind_r <= Q_NEAR_L;
    end
    if (state_r == S_LREAD && !under_r && op_r == OP_ADD_POINT && pcnt_r < PCntW'(MaxPoints)) begin
      px_mem[pcnt_r[PIdxW-1:0]] <= qx_r;
      py_mem[pcnt_r[PIdxW-1:0]] <= qy_r;
    end
    if (state_r == S_LREAD && !under_r && op_r == OP_ADD_LINK && lcnt_r < LCntW'(MaxLinks) &&
        PCntW'(ea_r) < pcnt_r && PCntW'(eb_r) < pcnt_r) begin
      la_mem[lcnt_r[LIdxW-1:0]] <= ea_r;
      lb_mem[lcnt_r[LIdxW-1:0]] <= eb_r;
    end
    if (state_r == S_EVAL && !skip && ev.better) best_r <= dist_sq;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pcnt_r <= '0;
      lcnt_r <= '0;
      radius_r <= HitRadiusRst;
      tol_r <= LineTolRst;
      out_valid <= 1'b0;
      i_r <= '0;
      found_r <= 1'b0;
      idx_r <= '0;
      status_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      out_valid <= state_r == S_DONE;
      if (cfg_we && cfg_index == CfgHitRadius) radius_r <= cfg_wdata[RadiusW-1:0];
      if (cfg_we && cfg_index == CfgLineTol) tol_r <= cfg_wdata[TolW-1:0];
      case (state_r)
        S_IDLE: begin
          i_r <= '0;
          found_r <= 1'b0;
          idx_r <= '0;
          status_r <= ST_OK;
        end
        S_LREAD: begin
          if (!under_r && op_r == OP_ADD_POINT) begin
            if (pcnt_r >= PCntW'(MaxPoints)) status_r <= ST_FULL;
            else begin
              idx_r <= 6'(pcnt_r);
              pcnt_r <= pcnt_r + PCntW'(1);
            end
          end else if (!under_r && op_r == OP_ADD_LINK) begin
            if (lcnt_r >= LCntW'(MaxLinks)) status_r <= ST_FULL;
            else if (PCntW'(ea_r) >= pcnt_r || PCntW'(eb_r) >= pcnt_r) status_r <= ST_NO_END;
            else begin
              idx_r <= 6'(lcnt_r);
              lcnt_r <= lcnt_r + LCntW'(1);
            end
          end
        end
        S_EVAL: begin
          if (kind_r == Q_HIT && ev.hit) begin
            found_r <= 1'b1;
            idx_r <= 6'(i_r);
          end else if (kind_r != Q_HIT && kind_r != Q_UNDER && !skip && ev.better) begin
            found_r <= 1'b1;
            idx_r <= 6'(i_r);
          end
          if (kind_r != Q_UNDER) i_r <= i_r + LCntW'(1);
        end
        S_CROSS: begin
          if (ev.hit) begin
            found_r <= 1'b1;
            idx_r <= 6'(i_r);
          end
          i_r <= i_r + LCntW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_status = status_r;
  assign out_found = found_r;
  assign out_found_index = idx_r;

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
  a_busy_until_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy at result");
  a_pcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCntW'(MaxPoints)) else $error("point count overflow");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ST_OK) else $error("found with error");

endmodule

// ===== tb/point_link_geometry_query_table_core_test.sv =====
module point_link_geometry_query_table_core_test;
  import plgq_pkg::*;

  typedef struct packed {
    logic [2:0] op;
    logic under;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [5:0] ea;
    logic [5:0] eb;
    logic [5:0] ex;
  } request_t;

  typedef struct packed {
    logic [1:0] status;
    logic found;
    logic [5:0] idx;
  } answer_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_op;
  logic in_op_under_link;
  logic signed [15:0] in_coord_x;
  logic signed [15:0] in_coord_y;
  logic [5:0] in_end_a_index;
  logic [5:0] in_end_b_index;
  logic [5:0] in_exclude_index;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_wdata;
  logic out_valid;
  logic [1:0] out_status;
  logic out_found;
  logic [5:0] out_found_index;

  point_link_geometry_query_table_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_op_under_link(in_op_under_link),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y),
    .in_end_a_index(in_end_a_index), .in_end_b_index(in_end_b_index),
    .in_exclude_index(in_exclude_index),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_status(out_status), .out_found(out_found),
    .out_found_index(out_found_index)
  );

  request_t pending_q[$];
  answer_t answer_q[$];

  logic signed [15:0] pt_x[MaxPoints];
  logic signed [15:0] pt_y[MaxPoints];
  logic [5:0] ln_a[MaxLinks];
  logic [5:0] ln_b[MaxLinks];
  int unsigned pt_count;
  int unsigned ln_count;
  int unsigned radius;
  int unsigned tolerance;

  int errors;
  int accepted;
  int answered;
  int found_hits;
  int idle_cycles;
  bit quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    $display("mismatch at answer %0d: %s got %0d expected %0d", answered, what, got, want);
    errors++;
  endtask

  function automatic void queue_request(input request_t r);
    pending_q = {pending_q, r};
  endfunction

  function automatic longint sq(input longint v);
    return v * v;
  endfunction

  function automatic longint iabs(input longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic answer_t predict_table_op(input request_t r);
    answer_t a;
    longint best, d, ax, ay, bx, by, cr, mx, my, qx, qy;
    a = '0;
    best = 0;
    qx = $signed(r.x);
    qy = $signed(r.y);
    if (r.under) begin
      for (int i = 0; i < ln_count; i++) begin
        ax = pt_x[ln_a[i]]; ay = pt_y[ln_a[i]];
        bx = pt_x[ln_b[i]]; by = pt_y[ln_b[i]];
        if (qx < (ax < bx ? ax : bx) || qx > (ax < bx ? bx : ax) ||
            qy < (ay < by ? ay : by) || qy > (ay < by ? by : ay)) continue;
        cr = (ax - bx) * (qy - by) - (ay - by) * (qx - bx);
        if (iabs(cr) < tolerance) begin
          a.found = 1'b1; a.idx = 6'(i);
          break;
        end
      end
    end else begin
      case (r.op)
        OP_ADD_POINT: begin
          if (pt_count >= MaxPoints) a.status = ST_FULL;
          else begin
            pt_x[pt_count] = r.x; pt_y[pt_count] = r.y;
            a.idx = 6'(pt_count); pt_count++;
          end
        end
        OP_ADD_LINK: begin
          if (ln_count >= MaxLinks) a.status = ST_FULL;
          else if (r.ea >= pt_count || r.eb >= pt_count) a.status = ST_NO_END;
          else begin
            ln_a[ln_count] = r.ea; ln_b[ln_count] = r.eb;
            a.idx = 6'(ln_count); ln_count++;
          end
        end
        OP_HIT_POINT: begin
          for (int i = 0; i < pt_count; i++) begin
            if (iabs(qx - pt_x[i]) <= radius &&
                iabs(qy - pt_y[i]) <= radius) begin
              a.found = 1'b1; a.idx = 6'(i);
              break;
            end
          end
        end
        OP_NEAR_POINT: begin
          for (int i = 0; i < pt_count; i++) begin
            if (i == r.ex) continue;
            d = sq(longint'(pt_x[i]) - qx) + sq(longint'(pt_y[i]) - qy);
            if (!a.found || d < best) begin
              best = d; a.found = 1'b1; a.idx = 6'(i);
            end
          end
        end
        OP_NEAR_LINK: begin
          for (int i = 0; i < ln_count; i++) begin
            if (i == r.ex) continue;
            mx = (longint'(pt_x[ln_a[i]]) + pt_x[ln_b[i]]) / 2;
            my = (longint'(pt_y[ln_a[i]]) + pt_y[ln_b[i]]) / 2;
            d = sq(mx - qx) + sq(my - qy);
            if (!a.found || d < best) begin
              best = d; a.found = 1'b1; a.idx = 6'(i);
            end
          end
        end
        default: ;
      endcase
    end
    return a;
  endfunction

  function automatic request_t mk(input logic [2:0] op, input logic under,
                                  input int x, input int y, input int ea,
                                  input int eb, input int ex);
    request_t r;
    r.op = op; r.under = under; r.x = 16'(x); r.y = 16'(y);
    r.ea = 6'(ea); r.eb = 6'(eb); r.ex = 6'(ex);
    return r;
  endfunction

  // position within spread of a stored point's coordinate, clamped to 16 bits
  function automatic int near_coord(input logic signed [15:0] c, input int spread);
    int v;
    v = int'(c) + $urandom_range(2 * spread) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic request_t rand_request(input int span);
    request_t r;
    int k, p, sel;
    r = '0;
    r.x = 16'($urandom);
    r.y = 16'($urandom);
    r.ea = 6'($urandom_range(63));
    r.eb = 6'($urandom_range(63));
    r.ex = 6'($urandom_range(63));
    if (span < 1000 && ($urandom_range(3) == 0)) begin
      r.x = 16'($signed(16'($urandom_range(2 * span))) - span);
      r.y = 16'($signed(16'($urandom_range(2 * span))) - span);
    end
    k = $urandom_range(99);
    if (k < 14) r.op = OP_ADD_POINT;
    else if (k < 26) r.op = OP_ADD_LINK;
    else if (k < 44) r.op = OP_HIT_POINT;
    else if (k < 62) r.op = OP_NEAR_POINT;
    else if (k < 76) r.op = OP_NEAR_LINK;
    else if (k < 80) r.op = 3'($urandom_range(5, 7));
    else begin
      r.op = 3'($urandom_range(7));
      r.under = 1'b1;
    end
    if (r.op == OP_ADD_LINK && pt_count > 0 && $urandom_range(9) != 0) begin
      r.ea = 6'($urandom_range(pt_count - 1));
      r.eb = 6'($urandom_range(pt_count - 1));
    end
    if (r.op == OP_ADD_POINT && span < 1000) begin
      r.x = 16'($signed(16'($urandom_range(2 * span))) - span);
      r.y = 16'($signed(16'($urandom_range(2 * span))) - span);
    end
    if (!r.under && r.op != OP_ADD_POINT && r.op != OP_ADD_LINK && pt_count > 0 &&
        $urandom_range(2) != 0) begin
      p = $urandom_range(pt_count - 1);
      r.x = 16'(near_coord(pt_x[p], 60));
      r.y = 16'(near_coord(pt_y[p], 60));
    end
    if (r.under && ln_count > 0 && $urandom_range(3) != 0) begin
      sel = $urandom_range(ln_count - 1);
      p = $urandom_range(16);
      r.x = 16'((longint'(pt_x[ln_a[sel]]) * p + longint'(pt_x[ln_b[sel]]) * (16 - p)) / 16);
      r.y = 16'((longint'(pt_y[ln_a[sel]]) * p + longint'(pt_y[ln_b[sel]]) * (16 - p)) / 16);
    end
    if ($urandom_range(4) == 0) r.ex = pt_count > 0 ? 6'($urandom_range(pt_count - 1)) : 6'(0);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      request_t taken;
      taken = pending_q.pop_front();
      answer_q = {answer_q, predict_table_op(taken)};
      accepted++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (pending_q.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
      start <= 1'b1;
      in_op <= pending_q[0].op;
      in_op_under_link <= pending_q[0].under;
      in_coord_x <= pending_q[0].x;
      in_coord_y <= pending_q[0].y;
      in_end_a_index <= pending_q[0].ea;
      in_end_b_index <= pending_q[0].eb;
      in_exclude_index <= pending_q[0].ex;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (answer_q.size() == 0) begin
        $display("unexpected answer: status %0d found %0d index %0d",
                 out_status, out_found, out_found_index);
        errors++;
      end else begin
        answer_t want;
        want = answer_q.pop_front();
        if (out_status !== want.status) report("status", out_status, want.status);
        if (out_found !== want.found) report("found", out_found, want.found);
        if (out_found_index !== want.idx) report("found_index", out_found_index, want.idx);
        if (want.found) found_hits++;
      end
      answered++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CfgW'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgHitRadius) radius = val & 10'h3ff;
    else tolerance = val & 16'hffff;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || answer_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic drain_if_needed();
    while (pending_q.size() > 0) @(posedge clk);
  endtask

  // state updates in predict_table_op happen on acceptance; random items
  // are generated against that state only after a drain
  task automatic run_phase(input int n, input int span);
    request_t r;
    for (int i = 0; i < n; i++) begin
      drain_if_needed();
      r = rand_request(span);
      queue_request(r);
    end
    drain();
  endtask

  initial begin
    quiet = 1'b0;
    radius = 40; tolerance = 1000;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty-table queries, extremes, endpoint errors, self link
    queue_request(mk(OP_HIT_POINT, 0, 0, 0, 0, 0, 0));
    queue_request(mk(OP_NEAR_LINK, 0, 0, 0, 0, 0, 0));
    queue_request(mk(OP_ADD_LINK, 0, 0, 0, 0, 0, 0));
    queue_request(mk(OP_ADD_POINT, 0, -32768, -32768, 0, 0, 0));
    queue_request(mk(OP_ADD_POINT, 0, 32767, 32767, 0, 0, 0));
    queue_request(mk(OP_ADD_POINT, 0, 32767, -32768, 0, 0, 0));
    queue_request(mk(OP_ADD_LINK, 0, 0, 0, 0, 63, 0));
    queue_request(mk(OP_ADD_LINK, 0, 0, 0, 3, 1, 0));
    queue_request(mk(OP_ADD_LINK, 0, 0, 0, 0, 1, 0));
    queue_request(mk(OP_ADD_LINK, 0, 0, 0, 2, 2, 0));
    queue_request(mk(OP_ADD_LINK, 0, 0, 0, 1, 2, 0));
    queue_request(mk(OP_HIT_POINT, 0, -32728, -32768, 0, 0, 0));
    queue_request(mk(OP_HIT_POINT, 0, -32727, -32768, 0, 0, 0));
    queue_request(mk(OP_NEAR_POINT, 0, 0, 0, 0, 0, 0));
    queue_request(mk(OP_NEAR_POINT, 0, 0, 0, 63, 0, 63));
    queue_request(mk(OP_NEAR_LINK, 0, 0, 0, 0, 0, 0));
    queue_request(mk(OP_NEAR_LINK, 0, -1, -1, 0, 0, 5));
    queue_request(mk(OP_ADD_POINT, 1, 0, 0, 0, 0, 0));
    queue_request(mk(OP_NEAR_LINK, 1, 32767, 0, 0, 0, 0));
    queue_request(mk(OP_HIT_POINT, 1, 32767, -32768, 0, 0, 0));
    queue_request(mk(3'd5, 0, 1, 1, 0, 0, 0));
    queue_request(mk(3'd7, 0, -1, -1, 63, 63, 63));
    drain();

    write_reg(CfgHitRadius, 0);
    write_reg(CfgLineTol, 0);
    queue_request(mk(OP_HIT_POINT, 0, 32767, 32767, 0, 0, 0));
    queue_request(mk(OP_ADD_LINK, 1, 32767, 32767, 0, 0, 0));
    drain();

    write_reg(CfgHitRadius, 1023);
    write_reg(CfgLineTol, 65535);
    run_phase(300, 3000);
    write_reg(CfgHitRadius, 40);
    write_reg(CfgLineTol, 1000);
    run_phase(450, 600);
    write_reg(CfgHitRadius, $urandom_range(1023));
    write_reg(CfgLineTol, $urandom);
    quiet = 1'b1;
    run_phase(250, 100000);
    quiet = 1'b0;
    write_reg(CfgHitRadius, 0);
    write_reg(CfgLineTol, 1);
    run_phase(300, 200);
    write_reg(CfgHitRadius, 1023);
    write_reg(CfgLineTol, 65535);
    run_phase(330, 100000);

    drain();
    repeat (200) @(posedge clk);
    $display("%0d requests accepted, %0d answers checked, %0d queries matched",
             accepted, answered, found_hits);
    $display("table ended with %0d points and %0d links", pt_count, ln_count);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
